[hdl/dlpg_pkg.sv]
package dlpg_pkg;

	// field widths
	localparam int CoordW = 16;
	localparam int AddrW  = 32;
	localparam int ColorW = 8;
	localparam int ErrW   = 18;
	localparam int DataW  = 32;
	localparam int PaddrW = 5;
	localparam int RegIdxW = 3;

	// input operation codes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	// register index (byte address / 4)
	typedef enum logic [RegIdxW-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_STRIDE = 3'd2,
		REG_RED    = 3'd3,
		REG_GREEN  = 3'd4,
		REG_BLUE   = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [CoordW-1:0] WidthRst  = 16'd640;
	localparam logic [CoordW-1:0] HeightRst = 16'd480;
	localparam logic [CoordW-1:0] StrideRst = 16'd640;
	localparam logic [ColorW-1:0] ColorRst  = 8'd0;

	// configuration seen by the datapath
	typedef struct packed {
		logic [CoordW-1:0] width;
		logic [CoordW-1:0] height;
		logic [CoordW-1:0] stride;
		logic [ColorW-1:0] red;
		logic [ColorW-1:0] green;
		logic [ColorW-1:0] blue;
	} cfg_t;

	// one pixel leaving the line walker
	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic              last;
	} pix_t;

endpackage

[hdl/dlpg_regs.sv]
module dlpg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dlpg_pkg::PaddrW-1:0]   paddr,
	input  logic [dlpg_pkg::DataW-1:0]    pwdata,
	output logic [dlpg_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	output dlpg_pkg::cfg_t                cfg
);

	dlpg_pkg::cfg_t cfg_q;
	logic [dlpg_pkg::RegIdxW-1:0] idx;
	logic wr_en;

	assign idx   = paddr[dlpg_pkg::PaddrW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	// register writes on the access phase; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= dlpg_pkg::WidthRst;
			cfg_q.height <= dlpg_pkg::HeightRst;
			cfg_q.stride <= dlpg_pkg::StrideRst;
			cfg_q.red    <= dlpg_pkg::ColorRst;
			cfg_q.green  <= dlpg_pkg::ColorRst;
			cfg_q.blue   <= dlpg_pkg::ColorRst;
		end else if (wr_en) begin
			case (idx)
				dlpg_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_HEIGHT: cfg_q.height <= pwdata[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_STRIDE: cfg_q.stride <= pwdata[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_RED:    cfg_q.red    <= pwdata[dlpg_pkg::ColorW-1:0];
				dlpg_pkg::REG_GREEN:  cfg_q.green  <= pwdata[dlpg_pkg::ColorW-1:0];
				dlpg_pkg::REG_BLUE:   cfg_q.blue   <= pwdata[dlpg_pkg::ColorW-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			dlpg_pkg::REG_WIDTH:  prdata = 32'(cfg_q.width);
			dlpg_pkg::REG_HEIGHT: prdata = 32'(cfg_q.height);
			dlpg_pkg::REG_STRIDE: prdata = 32'(cfg_q.stride);
			dlpg_pkg::REG_RED:    prdata = 32'(cfg_q.red);
			dlpg_pkg::REG_GREEN:  prdata = 32'(cfg_q.green);
			dlpg_pkg::REG_BLUE:   prdata = 32'(cfg_q.blue);
			default:              prdata = '0;
		endcase
	end

endmodule

[hdl/dlpg_walker.sv]
module dlpg_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [dlpg_pkg::CoordW-1:0]  start_x,
	input  logic [dlpg_pkg::CoordW-1:0]  start_y,
	input  logic [dlpg_pkg::CoordW-1:0]  end_x,
	input  logic [dlpg_pkg::CoordW-1:0]  end_y,
	input  logic                         s2_free,
	output logic                         pix_valid_s1,
	output dlpg_pkg::pix_t               pix_s1
);

	localparam int W = dlpg_pkg::CoordW;
	localparam int E = dlpg_pkg::ErrW;

	// line state
	logic                line_active_q;
	logic                y_major_q;
	logic                minor_down_q;
	logic [W-1:0]        major_pos_q;
	logic [W-1:0]        minor_pos_q;
	logic [W-1:0]        steps_left_q;
	logic [W-1:0]        major_span_q;
	logic [W-1:0]        minor_span_q;
	logic signed [E-1:0] err_q;

	logic acc, acc_load, acc_step;

	// load decode
	logic [W-1:0] adx, ady;
	logic         ld_ymaj, ld_swap, ld_down;
	logic [W-1:0] sm_raw, em_raw, sn_raw, en_raw;
	logic [W-1:0] sm, em, sn, en;
	logic [W-1:0] ld_major_span, ld_minor_span;

	// step arithmetic
	logic signed [E-1:0] ms_e, mj_e;
	logic signed [E-1:0] err_dn, err_dn_wrap, err_up, err_up_wrap;
	logic                last;

	assign in_ready = !pix_valid_s1 || s2_free;
	assign acc      = in_valid && in_ready;
	assign acc_load = acc && (op == dlpg_pkg::OP_LOAD);
	assign acc_step = acc && (op == dlpg_pkg::OP_STEP) && line_active_q;

	// endpoints: pick the major axis, then order so the major coordinate rises
	assign adx     = (start_x > end_x) ? start_x - end_x : end_x - start_x;
	assign ady     = (start_y > end_y) ? start_y - end_y : end_y - start_y;
	assign ld_ymaj = ady > adx;
	assign sm_raw  = ld_ymaj ? start_y : start_x;
	assign em_raw  = ld_ymaj ? end_y   : end_x;
	assign sn_raw  = ld_ymaj ? start_x : start_y;
	assign en_raw  = ld_ymaj ? end_x   : end_y;
	assign ld_swap = em_raw < sm_raw;
	assign sm      = ld_swap ? em_raw : sm_raw;
	assign em      = ld_swap ? sm_raw : em_raw;
	assign sn      = ld_swap ? en_raw : sn_raw;
	assign en      = ld_swap ? sn_raw : en_raw;
	assign ld_major_span = em - sm;
	assign ld_down       = en < sn;
	assign ld_minor_span = ld_down ? sn - en : en - sn;

	// error term update, both directions
	assign ms_e        = E'(signed'({2'b00, minor_span_q}));
	assign mj_e        = E'(signed'({2'b00, major_span_q}));
	assign err_dn      = err_q - ms_e;
	assign err_dn_wrap = err_dn + mj_e;
	assign err_up      = err_q + ms_e;
	assign err_up_wrap = err_up - mj_e;
	assign last        = (steps_left_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			y_major_q     <= 1'b0;
			minor_down_q  <= 1'b0;
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			steps_left_q  <= '0;
			major_span_q  <= '0;
			minor_span_q  <= '0;
			err_q         <= '0;
		end else if (acc_load) begin
			line_active_q <= 1'b1;
			y_major_q     <= ld_ymaj;
			minor_down_q  <= ld_down;
			major_pos_q   <= sm;
			minor_pos_q   <= sn;
			steps_left_q  <= ld_major_span;
			major_span_q  <= ld_major_span;
			minor_span_q  <= ld_minor_span;
			err_q         <= '0;
		end else if (acc_step) begin
			if (last) begin
				line_active_q <= 1'b0;
			end else begin
				steps_left_q <= steps_left_q - 1'b1;
				major_pos_q  <= major_pos_q + 1'b1;
				if (minor_down_q) begin
					if (err_dn < 0) begin
						err_q       <= err_dn_wrap;
						minor_pos_q <= minor_pos_q - 1'b1;
					end else begin
						err_q <= err_dn;
					end
				end else begin
					if (err_up >= mj_e) begin
						err_q       <= err_up_wrap;
						minor_pos_q <= minor_pos_q + 1'b1;
					end else begin
						err_q <= err_up;
					end
				end
			end
		end
	end

	// pixel stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (acc_step) begin
			pix_valid_s1 <= 1'b1;
		end else if (s2_free) begin
			pix_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_step) begin
			pix_s1.x    <= y_major_q ? minor_pos_q : major_pos_q;
			pix_s1.y    <= y_major_q ? major_pos_q : minor_pos_q;
			pix_s1.last <= last;
		end
	end

	// error term stays in [0, major_span) or is zero
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (err_q == '0) || (err_q >= 0 && err_q < mj_e))
		else $error("error term out of range");

	// minor span never exceeds the major span
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> minor_span_q <= major_span_q)
		else $error("minor span larger than major span");

	// a waiting pixel is not dropped while the output register is full
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_s1 && !s2_free |=> pix_valid_s1)
		else $error("pixel stage lost an item");

	// the last pixel ends the line
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		acc_step && last |=> !line_active_q)
		else $error("line still active after last pixel");

endmodule

[hdl/dda_line_pixel_generator_unit.sv]
// Line pixel generator.
// Input channel (in_valid/in_ready): op 0 loads a line from start_x/y and
// end_x/y and returns nothing; op 1 steps the line and returns one pixel,
// or nothing when no line is loaded. A load replaces any line in progress.
// Output channel (out_valid/out_ready): pixel_x, pixel_y, pixel_address
// (x + row_stride * y), visible (inside screen_width/screen_height), the
// color registers and last_pixel on the final pixel of the line.
// Throughput: one item per clock while in_ready is high. Each step is one
// add and compare on the error term, done at the transfer of the item.
// Pipeline: the first stage forms the coordinates of a stepped pixel, the
// second does the row multiply and drives the output.
// When out_ready is low the output holds and one more pixel is buffered in
// the first stage; in_ready drops only when both stages are full.
// Registers sit on an APB-style port at byte address 4*index, pready is
// always high. Reset clears the line (no line loaded), empties both stages
// and returns the registers to 640, 480, 640 and black.
module dda_line_pixel_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dlpg_pkg::PaddrW-1:0]   paddr,
	input  logic [dlpg_pkg::DataW-1:0]    pwdata,
	output logic [dlpg_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [dlpg_pkg::CoordW-1:0]   start_x,
	input  logic [dlpg_pkg::CoordW-1:0]   start_y,
	input  logic [dlpg_pkg::CoordW-1:0]   end_x,
	input  logic [dlpg_pkg::CoordW-1:0]   end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dlpg_pkg::CoordW-1:0]   pixel_x,
	output logic [dlpg_pkg::CoordW-1:0]   pixel_y,
	output logic [dlpg_pkg::AddrW-1:0]    pixel_address,
	output logic                          visible,
	output logic [dlpg_pkg::ColorW-1:0]   red_out,
	output logic [dlpg_pkg::ColorW-1:0]   green_out,
	output logic [dlpg_pkg::ColorW-1:0]   blue_out,
	output logic                          last_pixel
);

	dlpg_pkg::cfg_t cfg;
	dlpg_pkg::pix_t pix_s1;
	logic           pix_valid_s1;
	logic           s2_free;
	logic           valid_s2;
	logic [dlpg_pkg::AddrW-1:0] row_base;

	dlpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlpg_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.s2_free      (s2_free),
		.pix_valid_s1 (pix_valid_s1),
		.pix_s1       (pix_s1)
	);

	assign s2_free  = !valid_s2 || out_ready;
	assign row_base = dlpg_pkg::AddrW'(cfg.stride) * dlpg_pkg::AddrW'(pix_s1.y);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= pix_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && pix_valid_s1) begin
			pixel_x       <= pix_s1.x;
			pixel_y       <= pix_s1.y;
			pixel_address <= row_base + dlpg_pkg::AddrW'(pix_s1.x);
			visible       <= (pix_s1.x < cfg.width) && (pix_s1.y < cfg.height);
			red_out       <= cfg.red;
			green_out     <= cfg.green;
			blue_out      <= cfg.blue;
			last_pixel    <= pix_s1.last;
		end
	end

	assign out_valid = valid_s2;

	// a stalled output must not be overwritten by the pixel stage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2)
		else $error("output register dropped a pixel");

	// a buffered pixel moves to the output once it frees up
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_s1 && s2_free |=> valid_s2)
		else $error("pixel did not advance to the output");

	// input is held off only when both stages are occupied
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pix_valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled with room available");

endmodule

[test/dda_line_pixel_generator_unit_tb.sv]
`timescale 1ns / 1ps

module dda_line_pixel_generator_unit_tb;

	localparam int PHASES       = 6;
	localparam int QUIET_PHASE  = 0;
	localparam int HOLD_PHASE   = 3;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 290;
	localparam int DRAIN_CYCLES = 6;
	localparam int DIR_ROWS     = 25;
	localparam int END_WAIT     = 4000;

	// indexes past the register list, writes must be dropped
	localparam logic [dlpg_pkg::RegIdxW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [dlpg_pkg::RegIdxW-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [dlpg_pkg::CoordW-1:0] x;
		logic [dlpg_pkg::CoordW-1:0] y;
		logic [dlpg_pkg::AddrW-1:0]  addr;
		logic                        vis;
		logic [dlpg_pkg::ColorW-1:0] red;
		logic [dlpg_pkg::ColorW-1:0] green;
		logic [dlpg_pkg::ColorW-1:0] blue;
		logic                        last;
	} pixel_rec_t;

	// line walker state
	typedef struct {
		bit                               active;
		bit                               y_major;
		bit                               down;
		logic [dlpg_pkg::CoordW-1:0]      major;
		logic [dlpg_pkg::CoordW-1:0]      minor;
		logic [dlpg_pkg::CoordW-1:0]      left;
		logic [dlpg_pkg::CoordW-1:0]      major_span;
		logic [dlpg_pkg::CoordW-1:0]      minor_span;
		logic signed [dlpg_pkg::ErrW-1:0] err;
	} walk_t;

	typedef struct {
		dlpg_pkg::op_t               op;
		logic [dlpg_pkg::CoordW-1:0] sx;
		logic [dlpg_pkg::CoordW-1:0] sy;
		logic [dlpg_pkg::CoordW-1:0] ex;
		logic [dlpg_pkg::CoordW-1:0] ey;
		bit                          fixed;
		pixel_rec_t                  want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [dlpg_pkg::PaddrW-1:0]   paddr = '0;
	logic [dlpg_pkg::DataW-1:0]    pwdata = '0;
	logic [dlpg_pkg::DataW-1:0]    prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          op = 1'b0;
	logic [dlpg_pkg::CoordW-1:0]   start_x = '0;
	logic [dlpg_pkg::CoordW-1:0]   start_y = '0;
	logic [dlpg_pkg::CoordW-1:0]   end_x = '0;
	logic [dlpg_pkg::CoordW-1:0]   end_y = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [dlpg_pkg::CoordW-1:0]   pixel_x;
	logic [dlpg_pkg::CoordW-1:0]   pixel_y;
	logic [dlpg_pkg::AddrW-1:0]    pixel_address;
	logic                          visible;
	logic [dlpg_pkg::ColorW-1:0]   red_out;
	logic [dlpg_pkg::ColorW-1:0]   green_out;
	logic [dlpg_pkg::ColorW-1:0]   blue_out;
	logic                          last_pixel;

	dlpg_pkg::cfg_t screen_cfg;
	walk_t          walk;
	pixel_rec_t     pixel_q[$];
	dir_row_t       dir_tab[DIR_ROWS];

	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int err_cnt = 0;
	int n_load = 0;
	int n_step = 0;
	int n_checked = 0;
	int phase_items = 0;

	dda_line_pixel_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.visible(visible),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.last_pixel(last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("dda_line_pixel_generator_unit regression: fail");
		$finish;
	end

	// line walker: loads set up the walk, steps emit the current pixel and advance
	task automatic trace_line_item(input dlpg_pkg::op_t o,
			input logic [dlpg_pkg::CoordW-1:0] ax, ay, bx, by,
			output bit has, output pixel_rec_t p);
		logic [dlpg_pkg::CoordW-1:0] adx, ady, sm, em, sn, en, t;
		int e;
		has = 1'b0;
		p = '0;
		if (o == dlpg_pkg::OP_LOAD) begin
			adx = (ax > bx) ? ax - bx : bx - ax;
			ady = (ay > by) ? ay - by : by - ay;
			walk.y_major = ady > adx;
			if (walk.y_major) begin
				sm = ay; em = by; sn = ax; en = bx;
			end else begin
				sm = ax; em = bx; sn = ay; en = by;
			end
			// walk with the major coordinate rising
			if (em < sm) begin
				t = sm; sm = em; em = t;
				t = sn; sn = en; en = t;
			end
			walk.major = sm;
			walk.minor = sn;
			walk.major_span = em - sm;
			walk.down = en < sn;
			walk.minor_span = walk.down ? sn - en : en - sn;
			walk.left = walk.major_span;
			walk.err = '0;
			walk.active = 1'b1;
		end else if (walk.active) begin
			has = 1'b1;
			p.x = walk.y_major ? walk.minor : walk.major;
			p.y = walk.y_major ? walk.major : walk.minor;
			p.addr = dlpg_pkg::AddrW'(p.x)
				+ dlpg_pkg::AddrW'(screen_cfg.stride) * dlpg_pkg::AddrW'(p.y);
			p.vis = (p.x < screen_cfg.width) && (p.y < screen_cfg.height);
			p.red = screen_cfg.red;
			p.green = screen_cfg.green;
			p.blue = screen_cfg.blue;
			p.last = walk.left == '0;
			if (p.last) begin
				walk.active = 1'b0;
			end else begin
				walk.left = walk.left - 1'b1;
				walk.major = walk.major + 1'b1;
				e = int'(walk.err);
				// exact error term: minor moves when the accumulated slope crosses a unit
				if (walk.down) begin
					e = e - int'(walk.minor_span);
					if (e < 0) begin
						e = e + int'(walk.major_span);
						walk.minor = walk.minor - 1'b1;
					end
				end else begin
					e = e + int'(walk.minor_span);
					if (e >= int'(walk.major_span)) begin
						e = e - int'(walk.major_span);
						walk.minor = walk.minor + 1'b1;
					end
				end
				walk.err = dlpg_pkg::ErrW'(e);
			end
		end
	endtask

	// one input transfer; valid stays up between back-to-back items unless a random gap is put in outside the quiet phase
	task automatic send_item(input dlpg_pkg::op_t o,
			input logic [dlpg_pkg::CoordW-1:0] sx, sy, ex, ey,
			input bit fixed, input pixel_rec_t want);
		bit has;
		pixel_rec_t p;
		if (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		trace_line_item(o, sx, sy, ex, ey, has, p);
		if (has) pixel_q.push_back(fixed ? want : p);
		if (o == dlpg_pkg::OP_LOAD) n_load++;
		else n_step++;
		if (has || o == dlpg_pkg::OP_LOAD) phase_items++;
	endtask

	// APB transfer: setup then access cycle
	task automatic reg_xfer(input bit wr, input logic [dlpg_pkg::RegIdxW-1:0] idx,
			input logic [dlpg_pkg::DataW-1:0] val, output logic [dlpg_pkg::DataW-1:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			case (idx)
				dlpg_pkg::REG_WIDTH:  screen_cfg.width = val[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_HEIGHT: screen_cfg.height = val[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_STRIDE: screen_cfg.stride = val[dlpg_pkg::CoordW-1:0];
				dlpg_pkg::REG_RED:    screen_cfg.red = val[dlpg_pkg::ColorW-1:0];
				dlpg_pkg::REG_GREEN:  screen_cfg.green = val[dlpg_pkg::ColorW-1:0];
				dlpg_pkg::REG_BLUE:   screen_cfg.blue = val[dlpg_pkg::ColorW-1:0];
				default: ;
			endcase
		end
	endtask

	// write with junk above the field, then read back the masked value
	task automatic set_reg(input logic [dlpg_pkg::RegIdxW-1:0] idx,
			input logic [dlpg_pkg::DataW-1:0] value, input logic [dlpg_pkg::DataW-1:0] mask);
		logic [dlpg_pkg::DataW-1:0] rd;
		reg_xfer(1'b1, idx, ($urandom & ~mask) | value, rd);
		reg_xfer(1'b0, idx, '0, rd);
		if (rd !== value) begin
			err_cnt++;
			$display("%0t: register %0d readback expected %0d got %0d", $time, idx, value, rd);
		end
	endtask

	task automatic program_screen(input dlpg_pkg::cfg_t c);
		logic [dlpg_pkg::DataW-1:0] rd;
		set_reg(dlpg_pkg::REG_WIDTH, dlpg_pkg::DataW'(c.width), 32'h0000_FFFF);
		set_reg(dlpg_pkg::REG_HEIGHT, dlpg_pkg::DataW'(c.height), 32'h0000_FFFF);
		set_reg(dlpg_pkg::REG_STRIDE, dlpg_pkg::DataW'(c.stride), 32'h0000_FFFF);
		set_reg(dlpg_pkg::REG_RED, dlpg_pkg::DataW'(c.red), 32'h0000_00FF);
		set_reg(dlpg_pkg::REG_GREEN, dlpg_pkg::DataW'(c.green), 32'h0000_00FF);
		set_reg(dlpg_pkg::REG_BLUE, dlpg_pkg::DataW'(c.blue), 32'h0000_00FF);
		reg_xfer(1'b1, REG_SPARE_A, $urandom, rd);
		reg_xfer(1'b1, REG_SPARE_B, $urandom, rd);
	endtask

	// let every expected pixel out, plus the pipeline depth for no-result items
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [dlpg_pkg::CoordW-1:0] rand_coord();
		case ($urandom_range(9))
			0, 1: return dlpg_pkg::CoordW'($urandom);
			2: return 16'hFFFF - dlpg_pkg::CoordW'($urandom_range(0, 40));
			3: return dlpg_pkg::CoordW'($urandom_range(0, 40));
			default: return dlpg_pkg::CoordW'($urandom_range(0, 1100));
		endcase
	endfunction

	task automatic chk_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 15);
			end
		end
	end

	// pixel checker
	always @(posedge clk) begin
		pixel_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected pixel x=%0d y=%0d", $time, pixel_x, pixel_y);
			end else begin
				want = pixel_q.pop_front();
				chk_field("pixel_x", 32'(want.x), 32'(pixel_x));
				chk_field("pixel_y", 32'(want.y), 32'(pixel_y));
				chk_field("pixel_address", want.addr, pixel_address);
				chk_field("visible", 32'(want.vis), 32'(visible));
				chk_field("red_out", 32'(want.red), 32'(red_out));
				chk_field("green_out", 32'(want.green), 32'(green_out));
				chk_field("blue_out", 32'(want.blue), 32'(blue_out));
				chk_field("last_pixel", 32'(want.last), 32'(last_pixel));
				n_checked++;
			end
		end
	end

	initial begin
		int n;
		int r;
		int k;
		logic [dlpg_pkg::CoordW-1:0] sx, sy, ex, ey;
		dlpg_pkg::cfg_t phase_cfg[PHASES];

		// directed lines under the reset settings (640x480, stride 640, black)
		dir_tab = '{
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_LOAD, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 0, 0, 1, 0, 0, 0, 1}},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_LOAD, 65535, 65535, 65535, 65535, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 1, '{65535, 65535, 42007935, 0, 0, 0, 0, 1}},
			'{dlpg_pkg::OP_LOAD, 639, 479, 639, 479, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 1, '{639, 479, 307199, 1, 0, 0, 0, 1}},
			'{dlpg_pkg::OP_LOAD, 640, 0, 640, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 1, '{640, 0, 640, 0, 0, 0, 0, 1}},
			'{dlpg_pkg::OP_LOAD, 0, 480, 0, 480, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 480, 307200, 0, 0, 0, 0, 1}},
			'{dlpg_pkg::OP_LOAD, 13, 7, 10, 5, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_LOAD, 3, 0, 2, 10, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_LOAD, 0, 65535, 65535, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_STEP, 0, 0, 0, 0, 0, '0},
			'{dlpg_pkg::OP_LOAD, 65535, 0, 0, 65535, 0, '0}
		};

		// register settings per phase: all-ones, all-zeros, then mixed
		phase_cfg[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
		phase_cfg[1] = '{16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0};
		phase_cfg[2] = '{16'd320, 16'd200, 16'd512, 8'($urandom), 8'($urandom), 8'($urandom)};
		phase_cfg[3] = '{16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
			8'($urandom), 8'($urandom), 8'($urandom)};
		phase_cfg[4] = '{16'd100, 16'd100, 16'd1, 8'($urandom), 8'($urandom), 8'($urandom)};
		phase_cfg[5] = '{16'($urandom_range(0, 1100)), 16'($urandom_range(0, 800)),
			16'($urandom_range(1, 2048)), 8'($urandom), 8'($urandom), 8'($urandom)};

		screen_cfg = '{dlpg_pkg::WidthRst, dlpg_pkg::HeightRst, dlpg_pkg::StrideRst,
			dlpg_pkg::ColorRst, dlpg_pkg::ColorRst, dlpg_pkg::ColorRst};
		walk = '{default: '0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_item(dir_tab[i].op, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex,
				dir_tab[i].ey, dir_tab[i].fixed, dir_tab[i].want);
		end
		drain_pipe();

		for (int ph = 0; ph < PHASES; ph++) begin
			program_screen(phase_cfg[ph]);
			quiet = (ph == QUIET_PHASE);
			phase_items = 0;

			// long output hold-off against a steady stream of steps
			if (ph == HOLD_PHASE) begin
				send_item(dlpg_pkg::OP_LOAD, 16'd5, 16'd5, 16'd400, 16'd40, 1'b0, '0);
				hold_req = 1'b1;
				for (k = 0; k < 60; k++)
					send_item(dlpg_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), 1'b0, '0);
			end

			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 80) begin
					// well-formed: load a line and walk it, sometimes past the end
					sx = rand_coord();
					sy = rand_coord();
					if ($urandom_range(9) == 0) begin
						ex = dlpg_pkg::CoordW'($urandom);
						ey = dlpg_pkg::CoordW'($urandom);
					end else begin
						ex = sx + dlpg_pkg::CoordW'($urandom_range(0, 48)) - 16'd24;
						ey = sy + dlpg_pkg::CoordW'($urandom_range(0, 48)) - 16'd24;
					end
					send_item(dlpg_pkg::OP_LOAD, sx, sy, ex, ey, 1'b0, '0);
					n = int'(walk.left) + 1;
					if (n > 40) n = $urandom_range(1, 40);
					if ($urandom_range(3) == 0) n++;
					for (k = 0; k < n; k++)
						send_item(dlpg_pkg::OP_STEP, dlpg_pkg::CoordW'($urandom),
							dlpg_pkg::CoordW'($urandom), dlpg_pkg::CoordW'($urandom),
							dlpg_pkg::CoordW'($urandom), 1'b0, '0);
				end else if (r < 90) begin
					// noise: any op, any fields
					send_item(dlpg_pkg::op_t'($urandom_range(1)), dlpg_pkg::CoordW'($urandom),
						dlpg_pkg::CoordW'($urandom), dlpg_pkg::CoordW'($urandom),
						dlpg_pkg::CoordW'($urandom), 1'b0, '0);
				end else begin
					// broken: a few steps, then the next load cuts the line
					send_item(dlpg_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), 1'b0, '0);
					repeat ($urandom_range(0, 3))
						send_item(dlpg_pkg::OP_STEP, '0, '0, '0, '0, 1'b0, '0);
				end
			end
			drain_pipe();
		end

		in_valid <= 1'b0;
		k = 0;
		while (pixel_q.size() != 0 && k < END_WAIT) begin
			@(posedge clk);
			k++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixel_q.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected pixels never arrived", $time, pixel_q.size());
		end

		$display("covered %0d line loads and %0d step requests, %0d pixels checked",
			n_load, n_step, n_checked);
		$display("over %0d register settings incl. zero and full-scale screen and stride",
			PHASES + 1);
		if (err_cnt == 0) begin
			$display("dda_line_pixel_generator_unit regression: pass");
		end else begin
			$display("dda_line_pixel_generator_unit regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
hdl/dlpg_pkg.sv
hdl/dlpg_regs.sv
hdl/dlpg_walker.sv
hdl/dda_line_pixel_generator_unit.sv
test/dda_line_pixel_generator_unit_tb.sv
